>>> sv/htd_pkg.sv
package htd_pkg;

  localparam logic OP_NODE = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic start;
    logic walk;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic tree_complete;
    logic load_pops;
    logic decode_ok;
    logic walk_done;
    logic flush_done;
  } status_t;

endpackage

>>> sv/htd_in_if.sv
interface htd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic       node_is_leaf;
  logic [7:0] leaf_symbol;
  logic [7:0] data_byte;
  logic [3:0] valid_bits;

  modport source(output valid, opcode, node_is_leaf, leaf_symbol, data_byte, valid_bits,
                 input ready);
  modport sink(input valid, opcode, node_is_leaf, leaf_symbol, data_byte, valid_bits,
               output ready);
endinterface

>>> sv/htd_out_if.sv
interface htd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_in_run;

  modport source(output valid, symbol, last_in_run, input ready);
  modport sink(input valid, symbol, last_in_run, output ready);
endinterface

>>> sv/htd_ctrl.sv
module htd_ctrl
  import htd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    opcode,
  input  status_t sts,
  output logic    ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (fire) begin
          if (opcode == OP_NODE) begin
            cmd.load = 1'b1;
            if (sts.load_pops) begin
              state_next = S_POP;
            end
          end else if (sts.decode_ok) begin
            cmd.start  = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/htd_datapath.sv
module htd_datapath
  import htd_pkg::*;
#(
  parameter int TREE_NODES  = 511,
  parameter int STACK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    sts,
  input  logic       node_is_leaf,
  input  logic [7:0] leaf_symbol,
  input  logic [7:0] data_byte,
  input  logic [3:0] valid_bits,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] res_symbol,
  output logic       res_last
);

  localparam int NW  = $clog2(TREE_NODES);
  localparam int CW  = $clog2(TREE_NODES + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  // Node table: leaf flag and symbol per node, right links, pending stack.
  logic [8:0]    node_mem  [TREE_NODES];
  logic [NW-1:0] right_mem [TREE_NODES];
  logic [NW-1:0] stack_mem [STACK_DEPTH];

  logic [8:0]    node_rd;
  logic [NW-1:0] right_rd;
  logic [NW-1:0] stack_rd;

  logic           tree_complete;
  logic [CW-1:0]  nodes_loaded;
  logic [SCW-1:0] stack_count;
  logic [NW-1:0]  cursor;
  logic [NW-1:0]  cur_right;
  logic           root_leaf;
  logic [7:0]     root_sym;
  logic [NW-1:0]  root_right;
  logic [NW-1:0]  pop_link;

  logic          rd_pending;
  logic [NW-1:0] rd_addr;
  logic [7:0]    byte_sh;
  logic [3:0]    bits_left;
  logic          pend_valid;
  logic [7:0]    pend_sym;

  // Load-side signals.
  logic [CW-1:0]  eff_nodes;
  logic [SCW-1:0] eff_stack;
  logic [CW-1:0]  nxt_cnt;
  logic [NW-1:0]  node_idx;
  logic           ignored;
  logic           node_we;
  logic           push;
  logic           pop_rd;
  logic           completes;
  logic [SCW-1:0] stack_dec;

  // Walk-side signals.
  logic          node_rd_leaf;
  logic [NW-1:0] cur_c;
  logic [NW-1:0] cur_r;
  logic [NW:0]   cur_inc;
  logic [NW-1:0] next_addr;
  logic          emit;
  logic [7:0]    emit_sym;
  logic          res_free;
  logic          stall;
  logic          take_bit;
  logic          issue;
  logic          walk_go;
  logic          mid_push;
  logic          fin_push;

  always_comb begin
    eff_nodes = tree_complete ? '0 : nodes_loaded;
    eff_stack = tree_complete ? '0 : stack_count;
    nxt_cnt   = eff_nodes + CW'(1);
    node_idx  = eff_nodes[NW-1:0];
    stack_dec = eff_stack - SCW'(1);
    ignored   = (eff_nodes >= CW'(TREE_NODES)) ||
                (!node_is_leaf && (eff_stack >= SCW'(STACK_DEPTH)));
    node_we   = cmd.load && !ignored;
    push      = node_we && !node_is_leaf;
    completes = node_we && node_is_leaf && (eff_stack == '0);
    pop_rd    = node_we && node_is_leaf && (eff_stack != '0);
  end

  always_comb begin
    node_rd_leaf = node_rd[8];
    cur_c     = rd_pending ? (node_rd_leaf ? '0 : rd_addr) : cursor;
    cur_r     = rd_pending ? (node_rd_leaf ? root_right : right_rd) : cur_right;
    cur_inc   = {1'b0, cur_c} + (NW + 1)'(1);
    next_addr = byte_sh[7] ? cur_r :
                ((cur_inc == (NW + 1)'(TREE_NODES)) ? '0 : cur_inc[NW-1:0]);
    emit      = rd_pending ? node_rd_leaf : (root_leaf && (bits_left != '0));
    emit_sym  = rd_pending ? node_rd[7:0] : root_sym;
    res_free  = !res_valid || res_ready;
    stall     = emit && pend_valid && !res_free;
    walk_go   = cmd.walk && !stall;
    take_bit  = walk_go && (bits_left != '0);
    issue     = take_bit && !root_leaf;
    mid_push  = walk_go && emit && pend_valid;
    fin_push  = cmd.flush && pend_valid && res_free;
  end

  assign sts.tree_complete = tree_complete;
  assign sts.load_pops     = node_is_leaf && !tree_complete && (stack_count != '0) &&
                             (nodes_loaded < CW'(TREE_NODES));
  assign sts.decode_ok     = tree_complete && (valid_bits != '0);
  assign sts.walk_done     = (bits_left == '0) && !rd_pending;
  assign sts.flush_done    = !pend_valid || res_free;

  // Memories.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_idx] <= {node_is_leaf, leaf_symbol};
    end
    if (issue) begin
      node_rd <= node_mem[next_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      right_mem[stack_rd] <= pop_link;
    end
    if (issue) begin
      right_rd <= right_mem[next_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[eff_stack[SW-1:0]] <= node_idx;
    end
    if (pop_rd) begin
      stack_rd <= stack_mem[stack_dec[SW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_complete <= 1'b0;
      nodes_loaded  <= '0;
      stack_count   <= '0;
      cursor        <= '0;
      rd_pending    <= 1'b0;
      bits_left     <= '0;
      pend_valid    <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        tree_complete <= completes;
        nodes_loaded  <= node_we ? nxt_cnt : eff_nodes;
        if (push) begin
          stack_count <= eff_stack + SCW'(1);
        end else if (pop_rd) begin
          stack_count <= stack_dec;
        end else begin
          stack_count <= eff_stack;
        end
        if (tree_complete || completes) begin
          cursor <= '0;
        end
      end
      if (cmd.start) begin
        bits_left  <= (valid_bits > MAX_BITS) ? MAX_BITS : valid_bits;
        rd_pending <= 1'b0;
      end
      if (walk_go) begin
        cursor     <= cur_c;
        rd_pending <= issue;
        if (take_bit) begin
          bits_left <= bits_left - 4'd1;
        end
        if (emit) begin
          pend_valid <= 1'b1;
        end
      end
      if (fin_push) begin
        pend_valid <= 1'b0;
      end
      if (mid_push || fin_push) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (node_we && (node_idx == '0)) begin
      root_leaf <= node_is_leaf;
      root_sym  <= leaf_symbol;
    end
    if (pop_rd) begin
      pop_link <= (nxt_cnt == CW'(TREE_NODES)) ? '0 : nxt_cnt[NW-1:0];
    end
    if (cmd.pop && (stack_rd == '0)) begin
      root_right <= pop_link;
    end
    // The cursor sits on the root once a tree is complete.
    if (completes) begin
      cur_right <= root_right;
    end else if (walk_go) begin
      cur_right <= cur_r;
    end
    if (cmd.start) begin
      byte_sh <= data_byte;
    end else if (take_bit) begin
      byte_sh <= {byte_sh[6:0], 1'b0};
    end
    if (issue) begin
      rd_addr <= next_addr;
    end
    if (walk_go && emit) begin
      pend_sym <= emit_sym;
    end
    if (mid_push) begin
      res_symbol <= pend_sym;
      res_last   <= 1'b0;
    end else if (fin_push) begin
      res_symbol <= pend_sym;
      res_last   <= 1'b1;
    end
  end

endmodule

>>> sv/huffman_tree_load_and_decode.sv
// Node item: accepted in idle; a leaf that links a right child from the stack also
// passes through the pop state. Data item: the accept, one node-memory lookup per bit
// (none for a single-leaf tree), the end of the walk, then a flush of the held symbol;
// walk and flush can stall while the result register is full. A dropped data item, or
// one with zero valid bits, is only accepted. Results leave through an output register.
// Synchronous active-high reset clears the control state; tree tables are not cleared.
module huffman_tree_load_and_decode
  import htd_pkg::*;
#(
  parameter int TREE_NODES  = 511,
  parameter int STACK_DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  htd_in_if.sink     item,
  htd_out_if.source  result
);

  cmd_t    cmd;
  status_t sts;
  logic    ready;
  logic    fire;

  assign item.ready = ready;
  assign fire       = item.valid && ready;

  htd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .opcode (item.opcode),
    .sts    (sts),
    .ready  (ready),
    .cmd    (cmd)
  );

  htd_datapath #(
    .TREE_NODES  (TREE_NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .node_is_leaf (item.node_is_leaf),
    .leaf_symbol  (item.leaf_symbol),
    .data_byte    (item.data_byte),
    .valid_bits   (item.valid_bits),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_symbol   (result.symbol),
    .res_last     (result.last_in_run)
  );

`ifndef SYNTHESIS
  a_walk_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && !sts.walk_done |=> cmd.walk)
    else $error("decode walk ended before all bits were resolved");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk || cmd.flush || cmd.pop) |-> !ready)
    else $error("input accepted while an item is in progress");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.flush && sts.flush_done |=> ready)
    else $error("controller did not return to idle after flush");

  a_drop_incomplete: assert property (@(posedge clk) disable iff (rst)
    fire && (item.opcode == OP_DATA) && !sts.tree_complete |=> !cmd.walk)
    else $error("data decoded without a complete tree");
`endif

endmodule

>>> dv/tb_huffman_tree_load_and_decode.sv
`timescale 1ns / 1ps

module tb_huffman_tree_load_and_decode
  import htd_pkg::*;
;

  localparam int TREE_NODES   = 511;
  localparam int STACK_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int CALM_FIRST   = 3000;
  localparam int CALM_LAST    = 6000;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PERCENT = 24;

  typedef struct packed {
    logic       opcode;
    logic       node_is_leaf;
    logic [7:0] leaf_symbol;
    logic [7:0] data_byte;
    logic [3:0] valid_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_in_run;
  } decoded_t;

  logic clk;
  logic rst;
  int   cycle_count;
  int   error_count;
  int   stim_count;
  int   stall_left;
  bit   calm;

  htd_in_if  in_bus ();
  htd_out_if out_bus ();

  huffman_tree_load_and_decode dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_bus),
    .result (out_bus)
  );

  item_t    items_to_send[$];
  decoded_t expected_symbols[$];

  // Predicted decoder state: code tree tables, pending stack and walk cursor.
  logic        node_leaf  [TREE_NODES];
  logic [7:0]  node_sym   [TREE_NODES];
  logic [8:0]  node_right [TREE_NODES];
  logic [8:0]  open_stack [STACK_DEPTH];
  int unsigned open_count;
  int unsigned node_count;
  logic [8:0]  walk_pos;
  bit          tree_ready;

  function automatic logic [8:0] to_node(input int unsigned idx);
    return (idx < TREE_NODES) ? 9'(idx) : 9'd0;
  endfunction

  task automatic predict_symbols(input item_t it);
    int unsigned nbits;
    int unsigned n;
    int unsigned i;
    logic [8:0]  pos;
    logic        hit;
    logic [7:0]  hit_sym;
    decoded_t    held;
    bit          have_held;
    have_held = 1'b0;
    if (it.opcode == OP_NODE) begin
      if (tree_ready) begin
        tree_ready = 1'b0;
        node_count = 0;
        open_count = 0;
        walk_pos   = '0;
      end
      if (node_count >= TREE_NODES) return;
      if (!it.node_is_leaf && open_count >= STACK_DEPTH) return;
      n = node_count;
      node_leaf[n]  = it.node_is_leaf;
      node_sym[n]   = it.leaf_symbol;
      node_right[n] = '0;
      node_count    = n + 1;
      if (!it.node_is_leaf) begin
        open_stack[open_count] = 9'(n);
        open_count++;
      end else if (open_count == 0) begin
        tree_ready = 1'b1;
        walk_pos   = '0;
      end else begin
        open_count--;
        node_right[to_node(open_stack[open_count])] = 9'(n + 1);
      end
      return;
    end
    if (!tree_ready) return;
    nbits = (it.valid_bits > MAX_BITS) ? MAX_BITS : it.valid_bits;
    for (i = 0; i < nbits; i++) begin
      hit = 1'b0;
      hit_sym = '0;
      if (node_leaf[0]) begin
        // A tree that is a single leaf emits its symbol on every bit.
        hit = 1'b1;
        hit_sym = node_sym[0];
      end else begin
        pos = it.data_byte[7 - i] ? to_node(node_right[walk_pos]) : to_node(walk_pos + 1);
        if (node_leaf[pos]) begin
          hit = 1'b1;
          hit_sym = node_sym[pos];
        end else begin
          walk_pos = pos;
        end
      end
      if (hit) begin
        walk_pos = '0;
        if (have_held) expected_symbols.insert(expected_symbols.size(), held);
        held = '{symbol: hit_sym, last_in_run: 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last_in_run = 1'b1;
      expected_symbols.insert(expected_symbols.size(), held);
    end
  endtask

  task automatic push_node(input logic leaf, input logic [7:0] sym);
    item_t it;
    it.opcode       = OP_NODE;
    it.node_is_leaf = leaf;
    it.leaf_symbol  = sym;
    it.data_byte    = 8'($urandom);
    it.valid_bits   = 4'($urandom);
    items_to_send.insert(items_to_send.size(), it);
  endtask

  task automatic push_data(input logic [7:0] bits, input logic [3:0] nbits);
    item_t it;
    it.opcode       = OP_DATA;
    it.node_is_leaf = 1'($urandom);
    it.leaf_symbol  = 8'($urandom);
    it.data_byte    = bits;
    it.valid_bits   = nbits;
    items_to_send.insert(items_to_send.size(), it);
  endtask

  function automatic logic [3:0] random_bit_count();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return MAX_BITS;
    if (r < 90) return 4'($urandom_range(7, 1));
    if (r < 95) return 4'd0;
    return 4'($urandom_range(15, 9));
  endfunction

  // Emits a full binary tree in preorder. open_slots is the stack depth plus one.
  task automatic push_random_tree(input int unsigned internals, input bit with_noise);
    int unsigned open_slots;
    int unsigned left;
    open_slots = 1;
    left = internals;
    while (open_slots > 0) begin
      if (left > 0 && (open_slots == 1 || $urandom_range(1, 0) == 1)) begin
        push_node(1'b0, 8'($urandom));
        left--;
        open_slots++;
      end else begin
        push_node(1'b1, 8'($urandom));
        open_slots--;
      end
      stim_count++;
      // Data offered while the tree is still incomplete is dropped.
      if (with_noise && open_slots > 0 && $urandom_range(19, 0) == 0)
        push_data(8'($urandom), random_bit_count());
    end
  endtask

  task automatic push_random_run(input int unsigned bytes);
    repeat (bytes) begin
      push_data(8'($urandom), random_bit_count());
      stim_count++;
    end
  endtask

  task automatic build_stimulus();
    int unsigned internals;
    // Data with no tree loaded yet.
    push_data(8'hFF, MAX_BITS);
    // Tree of a single leaf.
    push_node(1'b1, 8'hA5);
    push_data(8'h00, MAX_BITS);
    push_data(8'hFF, 4'd15);
    push_data(8'h5A, 4'd0);
    push_data(8'h80, 4'd1);
    // A new tree replaces the old one; codes 0, 10 and 11.
    push_node(1'b0, 8'hFF);
    push_node(1'b1, 8'h00);
    push_data(8'hC3, MAX_BITS);
    push_node(1'b0, 8'h00);
    push_node(1'b1, 8'hFF);
    push_node(1'b1, 8'h7E);
    push_data(8'b1011_0100, MAX_BITS);
    // The walk stops inside the tree and resumes with the next byte.
    push_data(8'hFF, 4'd1);
    push_data(8'h7F, 4'd9);
    push_data(8'h00, 4'd4);
    push_data(8'hFF, MAX_BITS);

    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if ($urandom_range(7, 0) == 0) internals = $urandom_range(60, 9);
      else internals = $urandom_range(8, 0);
      push_random_tree(internals, 1'b1);
      push_random_run($urandom_range(12, 2));
    end

    // A left spine that fills the pending stack; one more internal node is ignored.
    // The tree can never complete, so this comes last.
    repeat (STACK_DEPTH) push_node(1'b0, 8'($urandom));
    push_node(1'b0, 8'($urandom));
    push_node(1'b1, 8'($urandom));
    push_data(8'($urandom), MAX_BITS);
    push_data(8'($urandom), MAX_BITS);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  // Item driver; the predictor runs on every transfer into the block.
  always @(posedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        predict_symbols('{opcode: in_bus.opcode, node_is_leaf: in_bus.node_is_leaf,
                          leaf_symbol: in_bus.leaf_symbol, data_byte: in_bus.data_byte,
                          valid_bits: in_bus.valid_bits});
      if (!in_bus.valid || in_bus.ready) begin
        if (items_to_send.size() != 0 &&
            (calm || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
          nxt = items_to_send.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.opcode       <= nxt.opcode;
          in_bus.node_is_leaf <= nxt.node_is_leaf;
          in_bus.leaf_symbol  <= nxt.leaf_symbol;
          in_bus.data_byte    <= nxt.data_byte;
          in_bus.valid_bits   <= nxt.valid_bits;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected result: symbol %0h last_in_run %0b",
                 out_bus.symbol, out_bus.last_in_run);
          error_count++;
        end else begin
          want = expected_symbols.pop_front();
          if (out_bus.symbol !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, out_bus.symbol);
            error_count++;
          end
          if (out_bus.last_in_run !== want.last_in_run) begin
            $error("last_in_run: expected %0b, got %0b", want.last_in_run,
                   out_bus.last_in_run);
            error_count++;
          end
        end
      end
      if (cycle_count == HOLD_START) stall_left <= HOLD_CYCLES;
      else if (stall_left != 0) stall_left <= stall_left - 1;
      out_bus.ready <= (stall_left == 0) &&
                       (calm || $urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cycle_count         = 0;
    error_count         = 0;
    open_count          = 0;
    node_count          = 0;
    walk_pos            = '0;
    tree_ready          = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = OP_NODE;
    in_bus.node_is_leaf = 1'b0;
    in_bus.leaf_symbol  = '0;
    in_bus.data_byte    = '0;
    in_bus.valid_bits   = '0;
    out_bus.ready       = 1'b0;
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (items_to_send.size() != 0 || in_bus.valid) @(negedge clk);
    while (expected_symbols.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_symbols.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> huffman_tree_load_and_decode.f
sv/htd_pkg.sv
sv/htd_in_if.sv
sv/htd_out_if.sv
sv/htd_ctrl.sv
sv/htd_datapath.sv
sv/huffman_tree_load_and_decode.sv
dv/tb_huffman_tree_load_and_decode.sv
